FILE: sv/x25519_pkg.sv
package x25519_pkg;

  localparam int WORD_BITS = 64;
  localparam int NWORDS    = 256 / WORD_BITS;
  localparam int WIDX_BITS = $clog2(NWORDS);
  localparam int FE_BITS   = 255;
  localparam int SLOT_BITS = 4;
  localparam int NSLOTS    = 16;

  // The field prime 2^255 - 19.
  localparam logic [FE_BITS-1:0] P_MOD = {{250{1'b1}}, 5'b01101};
  localparam logic [16:0]        A24_C = 17'd121665;

  typedef logic [SLOT_BITS-1:0] slot_t;

  // Register file slots. The two ladder points sit in slots 4 to 7 so that
  // a conditional swap becomes a flip of address bit 1.
  localparam slot_t SL_X1  = 4'd0;
  localparam slot_t SL_A24 = 4'd1;
  localparam slot_t SL_A   = 4'd2;
  localparam slot_t SL_AA  = 4'd3;
  localparam slot_t SL_X2  = 4'd4;
  localparam slot_t SL_Z2  = 4'd5;
  localparam slot_t SL_X3  = 4'd6;
  localparam slot_t SL_Z3  = 4'd7;
  localparam slot_t SL_B   = 4'd8;
  localparam slot_t SL_BB  = 4'd9;
  localparam slot_t SL_E   = 4'd10;
  localparam slot_t SL_C   = 4'd11;
  localparam slot_t SL_D   = 4'd12;
  localparam slot_t SL_DA  = 4'd13;
  localparam slot_t SL_CB  = 4'd14;
  localparam slot_t SL_T   = 4'd15;

  localparam int LADDER_OPS = 18;
  localparam int INIT_OPS   = 6;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_CPY = 3'd3,
    OP_SET = 3'd4,
    OP_OUT = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    IMM_U    = 2'd0,
    IMM_ONE  = 2'd1,
    IMM_ZERO = 2'd2,
    IMM_A24  = 2'd3
  } imm_e;

  typedef struct packed {
    op_e   op;
    slot_t dst;
    slot_t s1;
    slot_t s2;
    imm_e  imm;
  } uop_t;

  typedef struct packed {
    logic                 start;
    uop_t                 uop;
    logic                 load_we;
    logic [WIDX_BITS-1:0] load_idx;
    logic [7:0]           kpos;
    logic [WIDX_BITS-1:0] widx;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic kbit;
  } sts_t;

  typedef struct packed {
    logic [63:0] u_word;
    logic [63:0] k_word;
  } in_t;

  typedef struct packed {
    logic [63:0] result_word;
    logic        last_word;
  } out_t;

  function automatic uop_t mk_uop(op_e op, slot_t dst, slot_t s1, slot_t s2, imm_e imm);
    uop_t u;
    u.op  = op;
    u.dst = dst;
    u.s1  = s1;
    u.s2  = s2;
    u.imm = imm;
    return u;
  endfunction

  // One Montgomery ladder step, in ladder-point names before renaming.
  function automatic uop_t ladder_op(logic [4:0] idx);
    uop_t u;
    unique case (idx)
      5'd0:    u = mk_uop(OP_ADD, SL_A,  SL_X2,  SL_Z2, IMM_ZERO);
      5'd1:    u = mk_uop(OP_MUL, SL_AA, SL_A,   SL_A,  IMM_ZERO);
      5'd2:    u = mk_uop(OP_SUB, SL_B,  SL_X2,  SL_Z2, IMM_ZERO);
      5'd3:    u = mk_uop(OP_MUL, SL_BB, SL_B,   SL_B,  IMM_ZERO);
      5'd4:    u = mk_uop(OP_SUB, SL_E,  SL_AA,  SL_BB, IMM_ZERO);
      5'd5:    u = mk_uop(OP_ADD, SL_C,  SL_X3,  SL_Z3, IMM_ZERO);
      5'd6:    u = mk_uop(OP_SUB, SL_D,  SL_X3,  SL_Z3, IMM_ZERO);
      5'd7:    u = mk_uop(OP_MUL, SL_DA, SL_D,   SL_A,  IMM_ZERO);
      5'd8:    u = mk_uop(OP_MUL, SL_CB, SL_C,   SL_B,  IMM_ZERO);
      5'd9:    u = mk_uop(OP_ADD, SL_T,  SL_DA,  SL_CB, IMM_ZERO);
      5'd10:   u = mk_uop(OP_MUL, SL_X3, SL_T,   SL_T,  IMM_ZERO);
      5'd11:   u = mk_uop(OP_SUB, SL_T,  SL_DA,  SL_CB, IMM_ZERO);
      5'd12:   u = mk_uop(OP_MUL, SL_T,  SL_T,   SL_T,  IMM_ZERO);
      5'd13:   u = mk_uop(OP_MUL, SL_Z3, SL_X1,  SL_T,  IMM_ZERO);
      5'd14:   u = mk_uop(OP_MUL, SL_X2, SL_AA,  SL_BB, IMM_ZERO);
      5'd15:   u = mk_uop(OP_MUL, SL_T,  SL_A24, SL_E,  IMM_ZERO);
      5'd16:   u = mk_uop(OP_ADD, SL_T,  SL_AA,  SL_T,  IMM_ZERO);
      5'd17:   u = mk_uop(OP_MUL, SL_Z2, SL_E,   SL_T,  IMM_ZERO);
      default: u = mk_uop(OP_ADD, SL_T,  SL_T,   SL_T,  IMM_ZERO);
    endcase
    return u;
  endfunction

  function automatic uop_t init_op(logic [2:0] idx);
    uop_t u;
    unique case (idx)
      3'd0:    u = mk_uop(OP_SET, SL_X1,  SL_X1, SL_X1, IMM_U);
      3'd1:    u = mk_uop(OP_SET, SL_X2,  SL_X1, SL_X1, IMM_ONE);
      3'd2:    u = mk_uop(OP_SET, SL_Z2,  SL_X1, SL_X1, IMM_ZERO);
      3'd3:    u = mk_uop(OP_SET, SL_X3,  SL_X1, SL_X1, IMM_U);
      3'd4:    u = mk_uop(OP_SET, SL_Z3,  SL_X1, SL_X1, IMM_ONE);
      3'd5:    u = mk_uop(OP_SET, SL_A24, SL_X1, SL_X1, IMM_A24);
      default: u = mk_uop(OP_SET, SL_T,   SL_X1, SL_X1, IMM_ZERO);
    endcase
    return u;
  endfunction

  // Renames the two ladder points when the current scalar bit is set.
  function automatic slot_t map_slot(slot_t s, logic swap);
    return (swap && (s[3:2] == 2'b01)) ? (s ^ 4'd2) : s;
  endfunction

endpackage

FILE: sv/x25519_ram.sv
module x25519_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: sv/x25519_mul.sv
module x25519_mul import x25519_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [FE_BITS-1:0] a_i,
  input  logic [FE_BITS-1:0] b_i,
  output logic               done_o,
  output logic [FE_BITS-1:0] p_o
);

  typedef enum logic [7:0] {
    M_IDLE  = 8'b00000001,
    M_COL   = 8'b00000010,
    M_DRAIN = 8'b00000100,
    M_TOP   = 8'b00001000,
    M_RED   = 8'b00010000,
    M_FOLD1 = 8'b00100000,
    M_FOLD2 = 8'b01000000,
    M_FIN   = 8'b10000000
  } mul_state_e;

  mul_state_e st_q, st_d;

  logic [255:0] a_q, b_q;
  logic [3:0]   k_q, k_d;
  logic [2:0]   i_q, i_d;
  logic [2:0]   j_q, j_d;
  logic [63:0]  prod_q;
  logic         pv_q, pv_d;
  logic         plast_q;
  logic [3:0]   pk_q;
  logic [71:0]  acc_q, acc_d;
  logic [31:0]  t_q [16];
  logic [7:0]   c_q, c_d;
  logic [256:0] w_q;
  logic [255:0] v_q;
  logic         done_q;
  logic [FE_BITS-1:0] p_q;

  logic [3:0]   hi_k, lo_kn, kmi;
  logic [63:0]  prod_d;
  logic [71:0]  col_sum;
  logic         t_we;
  logic [3:0]   t_wa;
  logic [31:0]  t_wd;
  logic [39:0]  red_s;
  logic [255:0] lo256;
  logic [256:0] fin_d;

  for (genvar g = 0; g < 8; g++) begin : g_lo
    assign lo256[g*32 +: 32] = t_q[g];
  end

  assign hi_k   = (k_q < 4'd7) ? k_q : 4'd7;
  assign lo_kn  = (k_q >= 4'd7) ? (k_q - 4'd6) : 4'd0;
  assign kmi    = k_q - {1'b0, i_q};
  assign prod_d = a_q[i_q*32 +: 32] * b_q[kmi[2:0]*32 +: 32];

  assign col_sum = acc_q + {8'd0, prod_q};
  assign red_s   = 40'(t_q[{1'b0, j_q}]) + (40'(t_q[{1'b1, j_q}]) << 5)
                 + (40'(t_q[{1'b1, j_q}]) << 2) + (40'(t_q[{1'b1, j_q}]) << 1)
                 + 40'(c_q);
  assign fin_d   = {1'b0, v_q} - {2'b00, P_MOD};

  always_comb begin
    st_d  = st_q;
    k_d   = k_q;
    i_d   = i_q;
    j_d   = j_q;
    c_d   = c_q;
    pv_d  = 1'b0;
    acc_d = acc_q;
    t_we  = 1'b0;
    t_wa  = pk_q;
    t_wd  = col_sum[31:0];

    // Column accumulation adds the registered product into the accumulator.
    if (pv_q) begin
      if (plast_q) begin
        t_we  = 1'b1;
        acc_d = {32'd0, col_sum[71:32]};
      end else begin
        acc_d = col_sum;
      end
    end

    unique case (st_q)
      M_IDLE: begin
        if (start_i) begin
          st_d  = M_COL;
          k_d   = 4'd0;
          i_d   = 3'd0;
          acc_d = '0;
        end
      end
      M_COL: begin
        pv_d = 1'b1;
        if ({1'b0, i_q} == hi_k) begin
          if (k_q == 4'd14) begin
            st_d = M_DRAIN;
          end else begin
            k_d = k_q + 4'd1;
            i_d = lo_kn[2:0];
          end
        end else begin
          i_d = i_q + 3'd1;
        end
      end
      M_DRAIN: st_d = M_TOP;
      M_TOP: begin
        t_we = 1'b1;
        t_wa = 4'd15;
        t_wd = acc_q[31:0];
        j_d  = 3'd0;
        c_d  = 8'd0;
        st_d = M_RED;
      end
      M_RED: begin
        // Fold the upper half in with 2^256 = 38 mod p.
        t_we = 1'b1;
        t_wa = {1'b0, j_q};
        t_wd = red_s[31:0];
        c_d  = red_s[39:32];
        j_d  = j_q + 3'd1;
        if (j_q == 3'd7) begin
          st_d = M_FOLD1;
        end
      end
      M_FOLD1: st_d = M_FOLD2;
      M_FOLD2: st_d = M_FIN;
      M_FIN:   st_d = M_IDLE;
      default: st_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= M_IDLE;
      pv_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      pv_q   <= pv_d;
      done_q <= (st_q == M_FIN);
    end
  end

  always_ff @(posedge clk_i) begin
    if ((st_q == M_IDLE) && start_i) begin
      a_q <= {1'b0, a_i};
      b_q <= {1'b0, b_i};
    end
    k_q     <= k_d;
    i_q     <= i_d;
    j_q     <= j_d;
    c_q     <= c_d;
    acc_q   <= acc_d;
    prod_q  <= prod_d;
    plast_q <= ({1'b0, i_q} == hi_k);
    pk_q    <= k_q;
    if (t_we) begin
      t_q[t_wa] <= t_wd;
    end
    if (st_q == M_FOLD1) begin
      w_q <= 257'(lo256) + 257'(c_q) * 257'd38;
    end
    if (st_q == M_FOLD2) begin
      v_q <= 256'(w_q[254:0]) + 256'(w_q[256:255]) * 256'd19;
    end
    if (st_q == M_FIN) begin
      p_q <= fin_d[256] ? v_q[254:0] : fin_d[254:0];
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

FILE: sv/x25519_dp.sv
module x25519_dp import x25519_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  in_t         in_i,
  output sts_t        sts_o,
  output logic [63:0] res_word_o
);

  logic [WORD_BITS-1:0] u_st_q [NWORDS];
  logic [WORD_BITS-1:0] k_st_q [NWORDS];
  logic [255:0] u_full, k_full, k_cl;
  logic [FE_BITS-1:0] u_red;
  logic [FE_BITS:0]   u_sub;

  logic               rd_q, fin_q;
  op_e                op_q;
  slot_t              dst_q;
  logic [255:0]       s_q;
  logic [255:0]       res_q;

  logic               we;
  slot_t              wa;
  logic [FE_BITS-1:0] wd;
  logic [FE_BITS-1:0] qa, qb, imm_val, alu_res;
  logic [256:0]       add_chk;
  logic [255:0]       sub_fix;
  logic               mul_done;
  logic [FE_BITS-1:0] mul_res;
  logic               is_set;

  for (genvar g = 0; g < NWORDS; g++) begin : g_st
    assign u_full[g*WORD_BITS +: WORD_BITS] = u_st_q[g];
    assign k_full[g*WORD_BITS +: WORD_BITS] = k_st_q[g];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) begin
      u_st_q[cmd_i.load_idx] <= in_i.u_word[WORD_BITS-1:0];
      k_st_q[cmd_i.load_idx] <= in_i.k_word[WORD_BITS-1:0];
    end
  end

  // Top bit of u dropped, then brought below p.
  assign u_sub = {1'b0, u_full[254:0]} - {1'b0, P_MOD};
  assign u_red = u_sub[FE_BITS] ? u_full[254:0] : u_sub[FE_BITS-1:0];

  always_comb begin
    k_cl        = k_full;
    k_cl[2:0]   = 3'b000;
    k_cl[254]   = 1'b1;
    k_cl[255]   = 1'b0;
  end

  always_comb begin
    case (cmd_i.uop.imm)
      IMM_U:   imm_val = u_red;
      IMM_ONE: imm_val = FE_BITS'(1);
      IMM_A24: imm_val = FE_BITS'(A24_C);
      default: imm_val = '0;
    endcase
  end

  x25519_ram #(.WIDTH(FE_BITS), .DEPTH(NSLOTS)) u_rf (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (wa),
    .wdata_i   (wd),
    .raddr_a_i (cmd_i.uop.s1),
    .raddr_b_i (cmd_i.uop.s2),
    .rdata_a_o (qa),
    .rdata_b_o (qb)
  );

  x25519_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rd_q && (op_q == OP_MUL)),
    .a_i     (qa),
    .b_i     (qb),
    .done_o  (mul_done),
    .p_o     (mul_res)
  );

  assign is_set  = cmd_i.start && (cmd_i.uop.op == OP_SET);
  assign add_chk = {1'b0, s_q} - {2'b00, P_MOD};
  assign sub_fix = s_q + {1'b0, P_MOD};

  always_comb begin
    if (op_q == OP_SUB) begin
      alu_res = s_q[255] ? sub_fix[254:0] : s_q[254:0];
    end else begin
      alu_res = add_chk[256] ? s_q[254:0] : add_chk[254:0];
    end
  end

  always_comb begin
    we = 1'b0;
    wa = dst_q;
    wd = alu_res;
    if (is_set) begin
      we = 1'b1;
      wa = cmd_i.uop.dst;
      wd = imm_val;
    end else if (fin_q) begin
      we = 1'b1;
    end else if (mul_done) begin
      we = 1'b1;
      wd = mul_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      fin_q <= 1'b0;
    end else begin
      rd_q  <= cmd_i.start && !is_set;
      fin_q <= rd_q && ((op_q == OP_ADD) || (op_q == OP_SUB) || (op_q == OP_CPY));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q  <= cmd_i.uop.op;
      dst_q <= cmd_i.uop.dst;
    end
    if (rd_q) begin
      case (op_q)
        OP_SUB:  s_q <= {1'b0, qa} - {1'b0, qb};
        OP_CPY:  s_q <= {1'b0, qa};
        default: s_q <= {1'b0, qa} + {1'b0, qb};
      endcase
      if (op_q == OP_OUT) begin
        res_q <= {1'b0, qa};
      end
    end
  end

  assign sts_o.done = is_set || fin_q || mul_done || (rd_q && (op_q == OP_OUT));
  assign sts_o.kbit = k_cl[cmd_i.kpos];
  assign res_word_o = 64'(res_q[cmd_i.widx*WORD_BITS +: WORD_BITS]);

endmodule

FILE: sv/x25519_ctrl.sv
module x25519_ctrl import x25519_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic out_last_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [7:0] {
    C_LOAD = 8'b00000001,
    C_INIT = 8'b00000010,
    C_LAD  = 8'b00000100,
    C_CPY  = 8'b00001000,
    C_INV  = 8'b00010000,
    C_FIN  = 8'b00100000,
    C_CAP  = 8'b01000000,
    C_EMIT = 8'b10000000
  } ctl_state_e;

  ctl_state_e st_q, st_d;
  logic                 wait_q, wait_d;
  logic [WIDX_BITS-1:0] cnt_q, cnt_d;
  logic [WIDX_BITS-1:0] widx_q, widx_d;
  logic [4:0]           step_q, step_d;
  logic [7:0]           pos_q, pos_d;
  logic [7:0]           inv_q, inv_d;
  logic                 sub_q, sub_d;

  uop_t raw, mapped;
  logic work, accept, swap;

  assign accept = in_valid_i && (st_q == C_LOAD);
  assign work   = !((st_q == C_LOAD) || (st_q == C_EMIT));
  assign swap   = (st_q == C_LAD) && sts_i.kbit;

  always_comb begin
    unique case (st_q)
      C_INIT:  raw = init_op(step_q[2:0]);
      C_LAD:   raw = ladder_op(step_q);
      C_CPY:   raw = mk_uop(OP_CPY, SL_A, SL_Z2, SL_Z2, IMM_ZERO);
      C_INV:   raw = sub_q ? mk_uop(OP_MUL, SL_A, SL_A, SL_Z2, IMM_ZERO)
                           : mk_uop(OP_MUL, SL_A, SL_A, SL_A, IMM_ZERO);
      C_FIN:   raw = mk_uop(OP_MUL, SL_T, SL_X2, SL_A, IMM_ZERO);
      C_CAP:   raw = mk_uop(OP_OUT, SL_T, SL_T, SL_T, IMM_ZERO);
      default: raw = mk_uop(OP_OUT, SL_T, SL_T, SL_T, IMM_ZERO);
    endcase
    mapped     = raw;
    mapped.dst = map_slot(raw.dst, swap);
    mapped.s1  = map_slot(raw.s1, swap);
    mapped.s2  = map_slot(raw.s2, swap);
  end

  always_comb begin
    st_d   = st_q;
    wait_d = wait_q;
    cnt_d  = cnt_q;
    widx_d = widx_q;
    step_d = step_q;
    pos_d  = pos_q;
    inv_d  = inv_q;
    sub_d  = sub_q;

    if (work && sts_i.done) begin
      wait_d = 1'b0;
      unique case (st_q)
        C_INIT: begin
          if (step_q == 5'(INIT_OPS - 1)) begin
            st_d   = C_LAD;
            step_d = 5'd0;
            pos_d  = 8'd254;
          end else begin
            step_d = step_q + 5'd1;
          end
        end
        C_LAD: begin
          if (step_q == 5'(LADDER_OPS - 1)) begin
            step_d = 5'd0;
            if (pos_q == 8'd0) begin
              st_d = C_CPY;
            end else begin
              pos_d = pos_q - 8'd1;
            end
          end else begin
            step_d = step_q + 5'd1;
          end
        end
        C_CPY: begin
          st_d  = C_INV;
          inv_d = 8'd253;
          sub_d = 1'b0;
        end
        C_INV: begin
          if (sub_q || (inv_q == 8'd2) || (inv_q == 8'd4)) begin
            sub_d = 1'b0;
            if (inv_q == 8'd0) begin
              st_d = C_FIN;
            end else begin
              inv_d = inv_q - 8'd1;
            end
          end else begin
            sub_d = 1'b1;
          end
        end
        C_FIN: st_d = C_CAP;
        C_CAP: begin
          st_d   = C_EMIT;
          widx_d = '0;
        end
        default: st_d = C_LOAD;
      endcase
    end else if (work && !wait_q) begin
      wait_d = 1'b1;
    end

    if (accept) begin
      if (cnt_q == WIDX_BITS'(NWORDS - 1)) begin
        cnt_d  = '0;
        st_d   = C_INIT;
        step_d = 5'd0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end

    if ((st_q == C_EMIT) && !out_stall_i) begin
      if (widx_q == WIDX_BITS'(NWORDS - 1)) begin
        st_d = C_LOAD;
      end else begin
        widx_d = widx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= C_LOAD;
      wait_q <= 1'b0;
      cnt_q  <= '0;
      widx_q <= '0;
      step_q <= '0;
      pos_q  <= '0;
      inv_q  <= '0;
      sub_q  <= 1'b0;
    end else begin
      st_q   <= st_d;
      wait_q <= wait_d;
      cnt_q  <= cnt_d;
      widx_q <= widx_d;
      step_q <= step_d;
      pos_q  <= pos_d;
      inv_q  <= inv_d;
      sub_q  <= sub_d;
    end
  end

  assign cmd_o.start    = work && !wait_q;
  assign cmd_o.uop      = mapped;
  assign cmd_o.load_we  = accept;
  assign cmd_o.load_idx = cnt_q;
  assign cmd_o.kpos     = pos_q;
  assign cmd_o.widx     = widx_q;

  assign in_stall_o  = (st_q != C_LOAD);
  assign out_valid_o = (st_q == C_EMIT);
  assign out_last_o  = (widx_q == WIDX_BITS'(NWORDS - 1));

endmodule

FILE: sv/x25519_scalar_multiply_top.sv
// X25519 scalar multiplication. The u-coordinate and the scalar arrive as
// four 64-bit little-endian words, least significant word first, one word of
// each per accepted input word; the first three are taken one per cycle.
// After the fourth word the block clears the top bit of u, clamps the scalar,
// runs the 255-step Montgomery ladder, inverts z by raising it to p-2 and
// sends the fully reduced affine u-coordinate out as four words, the last
// one flagged. All field arithmetic goes through one register file of
// sixteen field elements and one shared 32x32-bit multiplier, so a field
// multiplication forms its 64 partial products in turn and then reduces
// the result. No new input is accepted until the last result word has been
// taken. A point at infinity yields zero.

module x25519_scalar_multiply_top import x25519_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  cmd_t        cmd;
  sts_t        sts;
  logic [63:0] res_word;
  logic        last;

  // The controller walks the load, init, ladder, inversion and output phases.
  x25519_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_last_o  (last),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the loaded words, the register file and the ALUs.
  x25519_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_i       (in_i),
    .sts_o      (sts),
    .res_word_o (res_word)
  );

  // The result register in the datapath holds the word steady while stalled.
  assign out_o.result_word = res_word;
  assign out_o.last_word   = last;

endmodule
